// ===== rtl/core/ipf_pkg.sv =====
package ipf_pkg;

    localparam int FIELD_W = 21;
    localparam int CFG_W   = 63;
    localparam int IDX_W   = 3;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 24;

    localparam int PR_W    = 45;
    localparam int SUM_W   = 47;
    localparam int RAY_W   = 29;
    localparam int DZ_W    = 22;
    localparam int OFS_W   = 51;
    localparam int N1_W    = 50;
    localparam int D1_W    = 29;
    localparam int Q1_W    = 23;

    localparam int FL_W    = 25;
    localparam int LP_W    = 42;
    localparam int LAB_W   = 44;
    localparam int LMAG_W  = 43;
    localparam int N2_W    = 59;
    localparam int D2_W    = 43;
    localparam int Q2_W    = 24;
    localparam int RES_W   = 26;

    localparam logic signed [FIELD_W-1:0] FLOOR_MAX = 21'sd1048575;
    localparam logic signed [FIELD_W-1:0] FLOOR_MIN = -21'sd1048576;
    localparam logic signed [OUT_W-1:0]   OUT_MAX   = 24'sd8388607;
    localparam logic signed [OUT_W-1:0]   OUT_MIN   = -24'sd8388608;

    localparam logic [CFG_W-1:0] ROT_X_RST = 63'd262144;
    localparam logic [CFG_W-1:0] ROT_Y_RST = 63'd549755813888;
    localparam logic [CFG_W-1:0] ROT_Z_RST = 63'd1152921504606846976;
    localparam logic [CFG_W-1:0] LAB_X_RST = 63'd32768;
    localparam logic [CFG_W-1:0] LAB_Y_RST = 63'd68719476736;
    localparam logic [CFG_W-1:0] LAB_W_RST = 63'd144115188075855872;

    typedef enum logic [IDX_W-1:0] {
        CFG_ROT_X = 3'd0,
        CFG_ROT_Y = 3'd1,
        CFG_ROT_Z = 3'd2,
        CFG_CAM   = 3'd3,
        CFG_LED   = 3'd4,
        CFG_LAB_X = 3'd5,
        CFG_LAB_Y = 3'd6,
        CFG_LAB_W = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0][CFG_W-1:0] rot;
        logic [CFG_W-1:0]      cam;
        logic [FIELD_W-1:0]    led;
        logic [2:0][CFG_W-1:0] lab;
    } t_cfg;

    typedef struct packed {
        logic neg_a;
        logic neg_b;
        logic flag;
        logic last;
    } t_div_side;

    function automatic logic signed [FIELD_W-1:0] fld(input logic [CFG_W-1:0] r,
                                                      input logic [1:0] k);
        return r[FIELD_W*k +: FIELD_W];
    endfunction

endpackage

// ===== rtl/core/ipf_ray.sv =====
module ipf_ray (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [ipf_pkg::IN_W-1:0]    i_image_x,
    input  logic signed [ipf_pkg::IN_W-1:0]    i_image_y,
    input  logic                               i_last,
    input  ipf_pkg::t_cfg                      i_cfg,
    output logic                               o_valid,
    output logic [ipf_pkg::N1_W-1:0]           o_num_x,
    output logic [ipf_pkg::N1_W-1:0]           o_num_y,
    output logic [ipf_pkg::D1_W-1:0]           o_den,
    output ipf_pkg::t_div_side                 o_side
);

    logic [3:0] r_val;
    logic [2:0] r_last;

    logic signed [ipf_pkg::PR_W-1:0]  r_p [6];
    logic signed [ipf_pkg::PR_W-1:0]  n_p [6];
    logic signed [ipf_pkg::RAY_W-1:0] r_ray [3];
    logic signed [ipf_pkg::RAY_W-1:0] n_ray [3];
    logic signed [ipf_pkg::SUM_W-1:0] w_sum [3];
    logic signed [ipf_pkg::OFS_W-1:0] r_ofs_x, r_ofs_y, n_ofs_x, n_ofs_y;
    logic signed [ipf_pkg::RAY_W-1:0] r_rz;
    logic signed [ipf_pkg::DZ_W-1:0]  w_dz;
    logic signed [ipf_pkg::OFS_W-1:0] w_abs_x, w_abs_y;
    logic signed [ipf_pkg::RAY_W-1:0] w_abs_z;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_p[2*r]   = ipf_pkg::PR_W'(ipf_pkg::fld(i_cfg.rot[r], 2'd0))
                       * ipf_pkg::PR_W'(i_image_x);
            n_p[2*r+1] = ipf_pkg::PR_W'(ipf_pkg::fld(i_cfg.rot[r], 2'd1))
                       * ipf_pkg::PR_W'(i_image_y);
            w_sum[r] = ipf_pkg::SUM_W'(r_p[2*r]) + ipf_pkg::SUM_W'(r_p[2*r+1])
                     + (ipf_pkg::SUM_W'(ipf_pkg::fld(i_cfg.rot[r], 2'd2)) <<< 20)
                     + 47'sd131072;
            n_ray[r] = ipf_pkg::RAY_W'(w_sum[r] >>> 18);
        end
        w_dz = ipf_pkg::DZ_W'(ipf_pkg::fld(i_cfg.cam, 2'd2))
             - ipf_pkg::DZ_W'($signed(i_cfg.led));
        n_ofs_x = ipf_pkg::OFS_W'(w_dz) * ipf_pkg::OFS_W'(r_ray[0]);
        n_ofs_y = ipf_pkg::OFS_W'(w_dz) * ipf_pkg::OFS_W'(r_ray[1]);
        w_abs_x = r_ofs_x[ipf_pkg::OFS_W-1] ? -r_ofs_x : r_ofs_x;
        w_abs_y = r_ofs_y[ipf_pkg::OFS_W-1] ? -r_ofs_y : r_ofs_y;
        w_abs_z = r_rz[ipf_pkg::RAY_W-1] ? -r_rz : r_rz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (i_en) begin
            r_val <= {r_val[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_last  <= {r_last[1:0], i_last};
            r_p     <= n_p;
            r_ray   <= n_ray;
            r_ofs_x <= n_ofs_x;
            r_ofs_y <= n_ofs_y;
            r_rz    <= r_ray[2];
            o_num_x <= w_abs_x[ipf_pkg::N1_W-1:0];
            o_num_y <= w_abs_y[ipf_pkg::N1_W-1:0];
            o_den   <= w_abs_z;
            o_side.neg_a <= r_ofs_x[ipf_pkg::OFS_W-1] ^ r_rz[ipf_pkg::RAY_W-1];
            o_side.neg_b <= r_ofs_y[ipf_pkg::OFS_W-1] ^ r_rz[ipf_pkg::RAY_W-1];
            o_side.flag  <= (r_rz == '0);
            o_side.last  <= r_last[2];
        end
    end

    assign o_valid = r_val[3];

endmodule

// ===== rtl/core/ipf_div.sv =====
module ipf_div #(
    parameter int NUM_W = ipf_pkg::N1_W,
    parameter int DEN_W = ipf_pkg::D1_W,
    parameter int Q_W   = ipf_pkg::Q1_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [NUM_W-1:0]   i_num_a,
    input  logic [NUM_W-1:0]   i_num_b,
    input  logic [DEN_W-1:0]   i_den,
    input  ipf_pkg::t_div_side i_side,
    output logic               o_valid,
    output logic [Q_W-1:0]     o_quo_a,
    output logic [Q_W-1:0]     o_quo_b,
    output ipf_pkg::t_div_side o_side
);

    localparam int D_W  = DEN_W + 1;
    localparam int N_W  = ((NUM_W + 1 > DEN_W) ? NUM_W + 1 : DEN_W) + 1;
    localparam int RW   = ((N_W > D_W + Q_W) ? N_W : D_W + Q_W) + 1;

    logic [Q_W:0]          r_val;
    logic [RW-1:0]         r_rem_a [Q_W+1];
    logic [RW-1:0]         r_rem_b [Q_W+1];
    logic [RW-1:0]         r_den   [Q_W+1];
    logic [Q_W-1:0]        r_quo_a [Q_W+1];
    logic [Q_W-1:0]        r_quo_b [Q_W+1];
    logic                  r_ovf_a [Q_W+1];
    logic                  r_ovf_b [Q_W+1];
    ipf_pkg::t_div_side    r_side  [Q_W+1];

    logic [RW-1:0] n_na, n_nb, n_d;

    always_comb begin
        n_na = (RW'(i_num_a) << 1) + RW'(i_den);
        n_nb = (RW'(i_num_b) << 1) + RW'(i_den);
        n_d  = RW'(i_den) << 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (i_en) begin
            r_val <= {r_val[Q_W-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_a[0] <= n_na;
            r_rem_b[0] <= n_nb;
            r_den[0]   <= n_d;
            r_quo_a[0] <= '0;
            r_quo_b[0] <= '0;
            r_ovf_a[0] <= n_na >= (n_d << Q_W);
            r_ovf_b[0] <= n_nb >= (n_d << Q_W);
            r_side[0]  <= i_side;
        end
    end

    for (genvar j = 1; j <= Q_W; j++) begin : g_stage
        localparam int K = Q_W - j;
        logic [RW-1:0] n_dk;
        logic          n_ge_a, n_ge_b;

        assign n_dk   = r_den[j-1] << K;
        assign n_ge_a = r_rem_a[j-1] >= n_dk;
        assign n_ge_b = r_rem_b[j-1] >= n_dk;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_a[j] <= n_ge_a ? r_rem_a[j-1] - n_dk : r_rem_a[j-1];
                r_rem_b[j] <= n_ge_b ? r_rem_b[j-1] - n_dk : r_rem_b[j-1];
                r_quo_a[j] <= r_quo_a[j-1] | (Q_W'(n_ge_a) << K);
                r_quo_b[j] <= r_quo_b[j-1] | (Q_W'(n_ge_b) << K);
                r_den[j]   <= r_den[j-1];
                r_ovf_a[j] <= r_ovf_a[j-1];
                r_ovf_b[j] <= r_ovf_b[j-1];
                r_side[j]  <= r_side[j-1];
            end
        end
    end

    assign o_valid = r_val[Q_W];
    assign o_quo_a = r_ovf_a[Q_W] ? '1 : r_quo_a[Q_W];
    assign o_quo_b = r_ovf_b[Q_W] ? '1 : r_quo_b[Q_W];
    assign o_side  = r_side[Q_W];

endmodule

// ===== rtl/core/ipf_lab.sv =====
module ipf_lab (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [ipf_pkg::Q1_W-1:0]     i_quo_x,
    input  logic [ipf_pkg::Q1_W-1:0]     i_quo_y,
    input  ipf_pkg::t_div_side           i_side,
    input  ipf_pkg::t_cfg                i_cfg,
    output logic                         o_valid,
    output logic [ipf_pkg::N2_W-1:0]     o_num_x,
    output logic [ipf_pkg::N2_W-1:0]     o_num_y,
    output logic [ipf_pkg::D2_W-1:0]     o_den,
    output ipf_pkg::t_div_side           o_side
);

    logic [3:0] r_val;
    logic [2:0] r_last, r_flag;

    logic signed [ipf_pkg::FL_W-1:0]    n_dx, n_dy, n_fx0, n_fy0;
    logic signed [ipf_pkg::FIELD_W-1:0] r_fx, r_fy, n_fx, n_fy;
    logic signed [ipf_pkg::LP_W-1:0]    r_p [6];
    logic signed [ipf_pkg::LP_W-1:0]    n_p [6];
    logic signed [ipf_pkg::LAB_W-1:0]   r_s [3];
    logic signed [ipf_pkg::LAB_W-1:0]   n_s [3];
    logic signed [ipf_pkg::LAB_W-1:0]   n_abs [3];

    always_comb begin
        n_dx = $signed({2'b00, i_quo_x});
        n_dy = $signed({2'b00, i_quo_y});
        if (i_side.neg_a) begin
            n_dx = -n_dx;
        end
        if (i_side.neg_b) begin
            n_dy = -n_dy;
        end
        n_fx0 = ipf_pkg::FL_W'(ipf_pkg::fld(i_cfg.cam, 2'd0)) - n_dx;
        n_fy0 = ipf_pkg::FL_W'(ipf_pkg::fld(i_cfg.cam, 2'd1)) - n_dy;
        if (n_fx0 > ipf_pkg::FL_W'(ipf_pkg::FLOOR_MAX)) begin
            n_fx = ipf_pkg::FLOOR_MAX;
        end else if (n_fx0 < ipf_pkg::FL_W'(ipf_pkg::FLOOR_MIN)) begin
            n_fx = ipf_pkg::FLOOR_MIN;
        end else begin
            n_fx = n_fx0[ipf_pkg::FIELD_W-1:0];
        end
        if (n_fy0 > ipf_pkg::FL_W'(ipf_pkg::FLOOR_MAX)) begin
            n_fy = ipf_pkg::FLOOR_MAX;
        end else if (n_fy0 < ipf_pkg::FL_W'(ipf_pkg::FLOOR_MIN)) begin
            n_fy = ipf_pkg::FLOOR_MIN;
        end else begin
            n_fy = n_fy0[ipf_pkg::FIELD_W-1:0];
        end
        for (int r = 0; r < 3; r++) begin
            n_p[2*r]   = ipf_pkg::LP_W'(ipf_pkg::fld(i_cfg.lab[r], 2'd0))
                       * ipf_pkg::LP_W'(r_fx);
            n_p[2*r+1] = ipf_pkg::LP_W'(ipf_pkg::fld(i_cfg.lab[r], 2'd1))
                       * ipf_pkg::LP_W'(r_fy);
            n_s[r] = ipf_pkg::LAB_W'(r_p[2*r]) + ipf_pkg::LAB_W'(r_p[2*r+1])
                   + (ipf_pkg::LAB_W'(ipf_pkg::fld(i_cfg.lab[r], 2'd2)) <<< 15);
            n_abs[r] = r_s[r][ipf_pkg::LAB_W-1] ? -r_s[r] : r_s[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (i_en) begin
            r_val <= {r_val[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fx   <= n_fx;
            r_fy   <= n_fy;
            r_p    <= n_p;
            r_s    <= n_s;
            r_last <= {r_last[1:0], i_side.last};
            r_flag <= {r_flag[1] | (r_val[1] && n_s[2] == '0), r_flag[0], i_side.flag};
            o_num_x <= {n_abs[0][ipf_pkg::LMAG_W-1:0], 16'b0};
            o_num_y <= {n_abs[1][ipf_pkg::LMAG_W-1:0], 16'b0};
            o_den   <= n_abs[2][ipf_pkg::LMAG_W-1:0];
            o_side.neg_a <= r_s[0][ipf_pkg::LAB_W-1] ^ r_s[2][ipf_pkg::LAB_W-1];
            o_side.neg_b <= r_s[1][ipf_pkg::LAB_W-1] ^ r_s[2][ipf_pkg::LAB_W-1];
            o_side.flag  <= r_flag[2];
            o_side.last  <= r_last[2];
        end
    end

    assign o_valid = r_val[3];

endmodule

// ===== rtl/core/image_point_to_floor_projection_top.sv =====
// Image point to lab floor position.
// Input channel: i_in_valid / o_in_stall with i_image_x, i_image_y (Q4.20)
// and i_last_point. A request is taken when i_in_valid is high and
// o_in_stall is low.
// Output channel: o_out_valid / i_out_stall with o_lab_x, o_lab_y (Q8.16),
// o_status and o_last_result, one result per request, in order.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// o_cfg_ready is always high. Write only while no request is in flight.
// The pipeline is four ray stages, the 24-stage floor divider, four
// lab stages, the 25-stage lab divider and the output register.
// Throughput is one request per cycle while the output is not stalled;
// the two restoring dividers, one quotient bit per stage, set the depth.
// When the output holds a result and i_out_stall is high, the whole
// pipeline holds and o_in_stall rises; nothing is dropped or repeated.
// Reset clears all valid bits and loads identity rotation and lab
// transforms, zero camera position and zero LED height.
module image_point_to_floor_projection_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [ipf_pkg::IN_W-1:0]   i_image_x,
    input  logic signed [ipf_pkg::IN_W-1:0]   i_image_y,
    input  logic                              i_last_point,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [ipf_pkg::OUT_W-1:0]  o_lab_x,
    output logic signed [ipf_pkg::OUT_W-1:0]  o_lab_y,
    output logic                              o_status,
    output logic                              o_last_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ipf_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [ipf_pkg::CFG_W-1:0]         i_cfg_data
);

    ipf_pkg::t_cfg      r_cfg;
    logic               w_en;

    logic                         w_ray_valid;
    logic [ipf_pkg::N1_W-1:0]     w_ray_nx, w_ray_ny;
    logic [ipf_pkg::D1_W-1:0]     w_ray_d;
    ipf_pkg::t_div_side           w_ray_side;

    logic                         w_fl_valid;
    logic [ipf_pkg::Q1_W-1:0]     w_fl_qx, w_fl_qy;
    ipf_pkg::t_div_side           w_fl_side;

    logic                         w_lab_valid;
    logic [ipf_pkg::N2_W-1:0]     w_lab_nx, w_lab_ny;
    logic [ipf_pkg::D2_W-1:0]     w_lab_d;
    ipf_pkg::t_div_side           w_lab_side;

    logic                         w_res_valid;
    logic [ipf_pkg::Q2_W-1:0]     w_res_qx, w_res_qy;
    ipf_pkg::t_div_side           w_res_side;

    logic signed [ipf_pkg::RES_W-1:0] n_vx, n_vy;
    logic signed [ipf_pkg::OUT_W-1:0] n_lab_x, n_lab_y;

    logic r_out_valid;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_en        = ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot[0] <= ipf_pkg::ROT_X_RST;
            r_cfg.rot[1] <= ipf_pkg::ROT_Y_RST;
            r_cfg.rot[2] <= ipf_pkg::ROT_Z_RST;
            r_cfg.cam    <= '0;
            r_cfg.led    <= '0;
            r_cfg.lab[0] <= ipf_pkg::LAB_X_RST;
            r_cfg.lab[1] <= ipf_pkg::LAB_Y_RST;
            r_cfg.lab[2] <= ipf_pkg::LAB_W_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (ipf_pkg::t_cfg_idx'(i_cfg_index))
                ipf_pkg::CFG_ROT_X: r_cfg.rot[0] <= i_cfg_data;
                ipf_pkg::CFG_ROT_Y: r_cfg.rot[1] <= i_cfg_data;
                ipf_pkg::CFG_ROT_Z: r_cfg.rot[2] <= i_cfg_data;
                ipf_pkg::CFG_CAM:   r_cfg.cam    <= i_cfg_data;
                ipf_pkg::CFG_LED:   r_cfg.led    <= i_cfg_data[ipf_pkg::FIELD_W-1:0];
                ipf_pkg::CFG_LAB_X: r_cfg.lab[0] <= i_cfg_data;
                ipf_pkg::CFG_LAB_Y: r_cfg.lab[1] <= i_cfg_data;
                ipf_pkg::CFG_LAB_W: r_cfg.lab[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ipf_ray u_ray (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_in_valid),
        .i_image_x (i_image_x),
        .i_image_y (i_image_y),
        .i_last    (i_last_point),
        .i_cfg     (r_cfg),
        .o_valid   (w_ray_valid),
        .o_num_x   (w_ray_nx),
        .o_num_y   (w_ray_ny),
        .o_den     (w_ray_d),
        .o_side    (w_ray_side)
    );

    ipf_div #(
        .NUM_W (ipf_pkg::N1_W),
        .DEN_W (ipf_pkg::D1_W),
        .Q_W   (ipf_pkg::Q1_W)
    ) u_div_floor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_ray_valid),
        .i_num_a (w_ray_nx),
        .i_num_b (w_ray_ny),
        .i_den   (w_ray_d),
        .i_side  (w_ray_side),
        .o_valid (w_fl_valid),
        .o_quo_a (w_fl_qx),
        .o_quo_b (w_fl_qy),
        .o_side  (w_fl_side)
    );

    ipf_lab u_lab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fl_valid),
        .i_quo_x (w_fl_qx),
        .i_quo_y (w_fl_qy),
        .i_side  (w_fl_side),
        .i_cfg   (r_cfg),
        .o_valid (w_lab_valid),
        .o_num_x (w_lab_nx),
        .o_num_y (w_lab_ny),
        .o_den   (w_lab_d),
        .o_side  (w_lab_side)
    );

    ipf_div #(
        .NUM_W (ipf_pkg::N2_W),
        .DEN_W (ipf_pkg::D2_W),
        .Q_W   (ipf_pkg::Q2_W)
    ) u_div_lab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_lab_valid),
        .i_num_a (w_lab_nx),
        .i_num_b (w_lab_ny),
        .i_den   (w_lab_d),
        .i_side  (w_lab_side),
        .o_valid (w_res_valid),
        .o_quo_a (w_res_qx),
        .o_quo_b (w_res_qy),
        .o_side  (w_res_side)
    );

    always_comb begin
        n_vx = $signed({2'b00, w_res_qx});
        n_vy = $signed({2'b00, w_res_qy});
        if (w_res_side.neg_a) begin
            n_vx = -n_vx;
        end
        if (w_res_side.neg_b) begin
            n_vy = -n_vy;
        end
        if (w_res_side.flag || n_vx > ipf_pkg::RES_W'(ipf_pkg::OUT_MAX)) begin
            n_lab_x = ipf_pkg::OUT_MAX;
        end else if (n_vx < ipf_pkg::RES_W'(ipf_pkg::OUT_MIN)) begin
            n_lab_x = ipf_pkg::OUT_MIN;
        end else begin
            n_lab_x = n_vx[ipf_pkg::OUT_W-1:0];
        end
        if (w_res_side.flag || n_vy > ipf_pkg::RES_W'(ipf_pkg::OUT_MAX)) begin
            n_lab_y = ipf_pkg::OUT_MAX;
        end else if (n_vy < ipf_pkg::RES_W'(ipf_pkg::OUT_MIN)) begin
            n_lab_y = ipf_pkg::OUT_MIN;
        end else begin
            n_lab_y = n_vy[ipf_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_lab_x       <= n_lab_x;
            o_lab_y       <= n_lab_y;
            o_status      <= w_res_side.flag;
            o_last_result <= w_res_side.last;
        end
    end

    assign o_out_valid = r_out_valid;

    a_status_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |->
            (o_lab_x == ipf_pkg::OUT_MAX && o_lab_y == ipf_pkg::OUT_MAX))
        else $error("zero divisor result not saturated");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled without a held result");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(w_res_valid))
        else $error("pipeline advanced during stall");

endmodule
